FILE: hw/rtl/pps_pkg.sv
package pps_pkg;

	// Screen geometry.
	localparam int unsigned SCREEN_WIDTH  = 240;
	localparam int unsigned SCREEN_HEIGHT = 64;

	localparam int unsigned FRAME_PIXELS    = SCREEN_WIDTH * SCREEN_HEIGHT;
	localparam int unsigned PACKED_BYTES    = FRAME_PIXELS / 8;
	localparam int unsigned LAST_BYTE_PIXEL = PACKED_BYTES * 8 - 1;
	localparam int unsigned POS_W           = $clog2(FRAME_PIXELS);

	localparam logic [31:0] LEN_WORD = 32'(PACKED_BYTES);

	// SLIP codes.
	localparam logic [7:0] SLIP_END     = 8'hc0;
	localparam logic [7:0] SLIP_ESC     = 8'hdb;
	localparam logic [7:0] SLIP_ESC_END = 8'hdc;
	localparam logic [7:0] SLIP_ESC_ESC = 8'hdd;

	// Result slots of one request: header bytes first, then the data byte,
	// its escape companion, and the frame terminator.
	localparam int unsigned HDR_LEN   = 11;
	localparam int unsigned NUM_SLOTS = HDR_LEN + 3;
	localparam int unsigned SLOT_W    = $clog2(NUM_SLOTS);

	localparam logic [SLOT_W-1:0] SLOT_DATA = SLOT_W'(HDR_LEN);
	localparam logic [SLOT_W-1:0] SLOT_ESC  = SLOT_W'(HDR_LEN + 1);
	localparam logic [SLOT_W-1:0] SLOT_TERM = SLOT_W'(HDR_LEN + 2);

	typedef logic [NUM_SLOTS-1:0] slot_mask_t;

	// Fixed command header, with the packed byte count big-endian in the middle.
	function automatic logic [7:0] hdr_byte(input logic [SLOT_W-1:0] idx);
		logic [7:0] b;
		unique case (idx)
			SLOT_W'(0): b = 8'h38;
			SLOT_W'(1): b = 8'h46;
			SLOT_W'(2): b = 8'h42;
			SLOT_W'(3): b = 8'h46;
			SLOT_W'(4): b = 8'h50;
			SLOT_W'(5): b = LEN_WORD[31:24];
			SLOT_W'(6): b = LEN_WORD[23:16];
			SLOT_W'(7): b = LEN_WORD[15:8];
			SLOT_W'(8): b = LEN_WORD[7:0];
			default:    b = 8'hff;
		endcase
		return b;
	endfunction

endpackage

FILE: hw/rtl/pixel_pack_slip_framer.sv
// Pixel packer and SLIP framer for a monochrome display command stream.
//
// Pixels enter on the in_valid/in_ready channel, one per request, in raster
// order. Each is XORed with invert_pixels and eight are packed MSB-first into
// a byte. The first pixel of a frame produces the fixed 11-byte header; every
// eighth pixel produces its packed byte, SLIP-escaped into one or two bytes;
// the pixel that completes the last byte also produces the 0xC0 terminator,
// flagged by frame_end. run_last marks the final result of each pixel.
// invert_pixels is written on the cfg_valid/cfg_ready channel, which is
// always ready and should only be used while the block is idle.
//
// The first result of a pixel moves from the result stage into the output
// register. Throughput: one pixel per cycle while each pixel gives at most one
// result and the receiver takes each byte; a pixel with more results holds
// in_ready low until its last is issued, as the result stage issues one byte
// per cycle when unstalled. A stalled receiver holds the output register, and
// a pixel waiting in the result stage then keeps in_ready low. Reset returns
// to the start of a frame with an empty pipeline and invert_pixels cleared.
module pixel_pack_slip_framer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       invert_pixels,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       pixel,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       frame_end,
	output logic       run_last
);
	import pps_pkg::*;

	// Frame state, updated as each pixel is accepted.
	logic [POS_W-1:0] pos_q;
	logic [6:0]       pack_q;
	logic             invert_q;

	// Result stage: the pending result slots of one pixel.
	logic       valid_s1;
	slot_mask_t pend_s1;
	logic [7:0] byte_s1;

	// Output register.
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       frame_end_q;
	logic       run_last_q;

	logic             accept;
	logic [7:0]       packed_byte;
	logic             in_frame;
	slot_mask_t       new_pend;
	logic             out_free;
	logic             issue;
	slot_mask_t       pick;
	slot_mask_t       pend_nxt;
	logic             issue_last;
	logic [SLOT_W-1:0] pick_idx;
	logic [7:0]       issue_byte;

	assign cfg_ready = 1'b1;
	assign accept    = in_valid && in_ready;

	// Work out what the incoming pixel produces.
	always_comb begin
		packed_byte = {pack_q, pixel ^ invert_q};
		in_frame    = pos_q <= POS_W'(LAST_BYTE_PIXEL);
		new_pend    = '0;
		if (pos_q == '0) begin
			new_pend[HDR_LEN-1:0] = '1;
		end
		if (in_frame && (pos_q[2:0] == 3'd7)) begin
			new_pend[SLOT_DATA] = 1'b1;
			new_pend[SLOT_ESC]  = (packed_byte == SLIP_END) || (packed_byte == SLIP_ESC);
		end
		new_pend[SLOT_TERM] = pos_q == POS_W'(LAST_BYTE_PIXEL);
	end

	// Issue the lowest pending slot each cycle the output register can take it.
	always_comb begin
		out_free   = !out_valid_q || out_ready;
		issue      = valid_s1 && out_free;
		pick       = pend_s1 & (~pend_s1 + 1'b1);
		pend_nxt   = pend_s1 & ~pick;
		issue_last = pend_nxt == '0;
		pick_idx   = '0;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			if (pick[i]) begin
				pick_idx = SLOT_W'(i);
			end
		end
		if (pick_idx == SLOT_DATA) begin
			issue_byte = pend_s1[SLOT_ESC] ? SLIP_ESC : byte_s1;
		end else if (pick_idx == SLOT_ESC) begin
			issue_byte = (byte_s1 == SLIP_END) ? SLIP_ESC_END : SLIP_ESC_ESC;
		end else if (pick_idx == SLOT_TERM) begin
			issue_byte = SLIP_END;
		end else begin
			issue_byte = hdr_byte(pick_idx);
		end
	end

	// The stage frees up when its last result moves to the output register.
	assign in_ready = !valid_s1 || (issue && issue_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			invert_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			invert_q <= invert_pixels;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			pack_q <= '0;
		end else if (accept) begin
			if (pos_q == POS_W'(FRAME_PIXELS - 1)) begin
				pos_q <= '0;
			end else begin
				pos_q <= pos_q + 1'b1;
			end
			if (in_frame) begin
				pack_q <= packed_byte[6:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= new_pend != '0;
		end else if (issue && issue_last) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pend_s1 <= new_pend;
			byte_s1 <= packed_byte;
		end else if (issue) begin
			pend_s1 <= pend_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (issue) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			out_byte_q  <= issue_byte;
			frame_end_q <= pick_idx == SLOT_TERM;
			run_last_q  <= issue_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign frame_end = frame_end_q;
	assign run_last  = run_last_q;

endmodule

FILE: hw/rtl/pps_checker.sv
module pps_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       frame_end,
	input logic       run_last
);
	import pps_pkg::*;

	// A stalled result holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte)
			&& $stable(frame_end) && $stable(run_last))
		else $error("stalled result changed");

	// The terminator is always the closing result of its pixel.
	a_term: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_end |-> run_last && (out_byte == SLIP_END))
		else $error("bad frame terminator");

	// Input is held back only while results are queued for the output.
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |=> out_valid)
		else $error("input stalled with no result pending");

	// Results of one pixel follow each other without a gap.
	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !run_last |=> out_valid)
		else $error("gap inside a pixel's results");

endmodule

bind pixel_pack_slip_framer pps_checker u_pps_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_byte  (out_byte),
	.frame_end (frame_end),
	.run_last  (run_last)
);
